### sv/mdhb_pkg.sv
// Shared types, codes and byte selection for the MAC data header builder.
`timescale 1ns / 1ps
package mdhb_pkg;

	localparam int HDR_MAX = 23;
	localparam int IDX_W = 5;

	localparam logic [1:0] ADDR_NONE  = 2'd0;
	localparam logic [1:0] ADDR_SHORT = 2'd2;
	localparam logic [1:0] ADDR_LONG  = 2'd3;

	localparam logic [2:0] FRAME_DATA  = 3'd1;
	localparam logic [4:0] OFF_DST_PAN = 5'd3;

	typedef struct packed {
		logic [15:0] fcf;
		logic [15:0] dst_pan_id;
		logic [15:0] src_pan_id;
		logic [15:0] dst_short;
		logic [15:0] src_short;
		logic [63:0] dst_long;
		logic [63:0] src_long;
		logic [1:0]  dst_mode;
		logic [4:0]  off_daddr;
		logic [4:0]  off_span;
		logic [4:0]  off_saddr;
		logic [4:0]  len;
		logic        err;
	} hdr_load_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
		logic       status;
		logic [4:0] len;
	} hdr_slot_t;

	function automatic logic [4:0] addr_len(input logic [1:0] mode);
		logic [4:0] r;
		begin
			case (mode)
				ADDR_SHORT: r = 5'd2;
				ADDR_LONG:  r = 5'd8;
				default:    r = 5'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [7:0] hdr_pick(input logic [IDX_W-1:0] idx,
		input hdr_load_t ld);
		logic [7:0]       r;
		logic [4:0]       rel_d;
		logic [4:0]       rel_p;
		logic [4:0]       rel_s;
		logic [7:0][7:0]  dl;
		logic [7:0][7:0]  sl;
		begin
			dl = ld.dst_long;
			sl = ld.src_long;
			rel_d = idx - ld.off_daddr;
			rel_p = idx - ld.off_span;
			rel_s = idx - ld.off_saddr;
			if (idx == 5'd0) begin
				r = ld.fcf[7:0];
			end else if (idx == 5'd1) begin
				r = ld.fcf[15:8];
			end else if (idx < OFF_DST_PAN) begin
				r = 8'd0;
			end else if (idx < ld.off_daddr) begin
				r = idx[0] ? ld.dst_pan_id[7:0] : ld.dst_pan_id[15:8];
			end else if (idx < ld.off_span) begin
				if (ld.dst_mode == ADDR_SHORT) begin
					r = rel_d[0] ? ld.dst_short[15:8] : ld.dst_short[7:0];
				end else begin
					r = dl[~rel_d[2:0]];
				end
			end else if (idx < ld.off_saddr) begin
				r = rel_p[0] ? ld.src_pan_id[15:8] : ld.src_pan_id[7:0];
			end else if (ld.fcf[15:14] == ADDR_SHORT) begin
				r = rel_s[0] ? ld.src_short[15:8] : ld.src_short[7:0];
			end else begin
				r = sl[~rel_s[2:0]];
			end
			return r;
		end
	endfunction

endpackage

### sv/mdhb_cell.sv
// One header byte cell: loads its own byte of a new header, else takes its neighbor's.
`timescale 1ns / 1ps
module mdhb_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [mdhb_pkg::IDX_W-1:0]   idx,
	input  mdhb_pkg::hdr_load_t          ld,
	input  mdhb_pkg::hdr_slot_t          nxt,
	output mdhb_pkg::hdr_slot_t          slot
);

	mdhb_pkg::hdr_slot_t fill;
	logic                valid_q;
	logic [7:0]          data_q;
	logic                last_q;
	logic                status_q;
	logic [4:0]          len_q;

	always_comb begin
		fill.data = mdhb_pkg::hdr_pick(idx, ld);
		if (ld.err) begin
			fill.valid  = (idx == '0);
			fill.data   = 8'd0;
			fill.last   = 1'b1;
			fill.status = 1'b1;
			fill.len    = 5'd0;
		end else begin
			fill.valid  = (idx < ld.len);
			fill.last   = (idx == ld.len - 5'd1);
			fill.status = 1'b0;
			fill.len    = ld.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= fill.valid;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= fill.data;
			last_q   <= fill.last;
			status_q <= fill.status;
			len_q    <= fill.len;
		end else begin
			data_q   <= nxt.data;
			last_q   <= nxt.last;
			status_q <= nxt.status;
			len_q    <= nxt.len;
		end
	end

	assign slot.valid  = valid_q;
	assign slot.data   = data_q;
	assign slot.last   = last_q;
	assign slot.status = status_q;
	assign slot.len    = len_q;

endmodule

### sv/mac_data_header_builder.sv
// Top level of the MAC data header builder: request decode and the byte cell chain.
`timescale 1ns / 1ps
// Usage:
// - A request is taken at a rising edge with start high and busy low. All
//   addressing fields and buffer_capacity are sampled at that edge.
// - The whole header is loaded at once into a chain of 23 byte cells; the
//   chain advances one cell toward the head every cycle and the head cell
//   drives the result ports.
// - The first result appears in the cycle after the request is taken. One
//   byte follows per cycle with no gaps, strobe high on each, last_byte high
//   on the final one; hdr_len and status are repeated on every byte.
// - A header of N bytes (3 to 23) is given one byte at a time; busy is low while
//   the final byte is shown, so the next request may be taken then and its first
//   byte follows directly.
// - If buffer_capacity is below the header length, a single result with
//   status 1, header_byte 0, hdr_len 0 and last_byte 1 is given.
// - The receiver cannot stall: every strobed result is taken in its cycle.
// - Reset empties the chain; no result is pending after reset.
module mac_data_header_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  src_mode,
	input  logic [1:0]  dst_mode,
	input  logic        src_pan_given,
	input  logic [15:0] src_pan_id,
	input  logic        dst_pan_given,
	input  logic [15:0] dst_pan_id,
	input  logic [15:0] src_short,
	input  logic [15:0] dst_short,
	input  logic [63:0] src_long,
	input  logic [63:0] dst_long,
	input  logic [7:0]  buffer_capacity,
	output logic        strobe,
	output logic [7:0]  header_byte,
	output logic        last_byte,
	output logic        status,
	output logic [4:0]  hdr_len
);

	mdhb_pkg::hdr_load_t ld;
	mdhb_pkg::hdr_slot_t slots [mdhb_pkg::HDR_MAX+1];
	logic                compress;
	logic                span_emit;
	logic                load;

	always_comb begin
		compress = src_pan_given && dst_pan_given && (src_mode != mdhb_pkg::ADDR_NONE)
			&& (dst_mode != mdhb_pkg::ADDR_NONE) && (src_pan_id == dst_pan_id);
		span_emit = src_pan_given && !compress;
		ld.fcf = {src_mode, 2'b00, dst_mode, 3'b000, compress, 3'b000,
			mdhb_pkg::FRAME_DATA};
		ld.dst_pan_id = dst_pan_id;
		ld.src_pan_id = src_pan_id;
		ld.dst_short  = dst_short;
		ld.src_short  = src_short;
		ld.dst_long   = dst_long;
		ld.src_long   = src_long;
		ld.dst_mode   = dst_mode;
		ld.off_daddr  = mdhb_pkg::OFF_DST_PAN + {3'b000, dst_pan_given, 1'b0};
		ld.off_span   = ld.off_daddr + mdhb_pkg::addr_len(dst_mode);
		ld.off_saddr  = ld.off_span + {3'b000, span_emit, 1'b0};
		ld.len        = ld.off_saddr + mdhb_pkg::addr_len(src_mode);
		ld.err        = (buffer_capacity < {3'b000, ld.len});
	end

	assign busy = slots[1].valid;
	assign load = start && !busy;

	assign slots[mdhb_pkg::HDR_MAX] = '0;

	for (genvar i = 0; i < mdhb_pkg::HDR_MAX; i++) begin : g_cell
		mdhb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (load),
			.idx    (mdhb_pkg::IDX_W'(i)),
			.ld     (ld),
			.nxt    (slots[i+1]),
			.slot   (slots[i])
		);
	end

	assign strobe      = slots[0].valid;
	assign header_byte = slots[0].data;
	assign last_byte   = slots[0].last;
	assign status      = slots[0].status;
	assign hdr_len     = slots[0].len;

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status |-> last_byte && hdr_len == 5'd0 && header_byte == 8'd0)
		else $error("error result malformed");

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe)
		else $error("accepted item gave no result in next cycle");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_byte |=> strobe && !status)
		else $error("gap inside a header");

	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> strobe && !last_byte)
		else $error("busy without a header in progress");

endmodule
